>>> rtl/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
package tcce_pkg;

    // Cell index space
    localparam int CELL_AW   = 14;
    localparam int MEM_CELLS = 1 << CELL_AW;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_CELLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CURSOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ACTIVE = 3'd4;

    // Register reset values
    localparam logic [13:0] RST_REGION_BASE    = 14'd0;
    localparam logic [14:0] RST_REGION_CELLS   = 15'd5461;
    localparam logic [13:0] RST_START_CURSOR   = 14'd0;
    localparam logic [7:0]  RST_TEXT_ATTR      = 8'd7;
    localparam logic        RST_DISPLAY_ACTIVE = 1'b1;

    // Character codes
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] ERASE_ATTR   = 8'h07;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;     // clearing sweep write
        logic accept;  // latch incoming item
        logic mul;     // offset times reciprocal
        logic qmul;    // quotient times line length
        logic rem;     // remainder ready, apply character
        logic walk;    // backspace walk over spaces
        logic up;      // scroll-up check
        logic dn;      // scroll-down check and result load
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic walk;       // backspace starts a space walk
        logic bs_hit;     // backspace acted (cursor above base)
        logic walk_more;  // walk continues
        logic out_free;   // result register can take a new item
    } t_dp_sts;

endpackage

>>> rtl/text_console_cursor_engine_core.sv
// Top level of the text console cursor and scroll engine.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+-------------------------------
//  char     | in        | i_char_valid / o_char_stall    | i_char_code
//  result   | out       | o_res_valid / i_res_stall      | cursor, view top, strobes, cell
//  config   | in        | i_cfg_wr_en                    | i_cfg_index, i_cfg_data
//
//  Newline and printed items step from accept through multiply, scale, remainder/apply and
//  scroll-down/result load back to idle. A backspace above the base adds a scroll-up step
//  and, where it walks back over spaces, walk steps, each paced by the flag memory read.
//  After reset a sweep clears every cell of the flag memory; input stalls until done.
//  The next item is accepted while a result waits; a new result waits in the
//  scroll-down step only while the result register is still held by i_res_stall.
module text_console_cursor_engine_core #(
    parameter int LINE_CELLS = 80,
    parameter int VIEW_CELLS = 2000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_char_valid,
    output logic                                o_char_stall,
    input  logic [7:0]                          i_char_code,
    output logic                                o_res_valid,
    input  logic                                i_res_stall,
    output logic [13:0]                         o_cursor_out,
    output logic [13:0]                         o_view_top_out,
    output logic                                o_cursor_reg_write,
    output logic                                o_start_reg_write,
    output logic                                o_cell_write,
    output logic [13:0]                         o_cell_addr,
    output logic [7:0]                          o_cell_char,
    output logic [7:0]                          o_cell_attr
);
    import tcce_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    tcce_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (i_char_valid),
        .o_char_stall (o_char_stall),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // Datapath
    tcce_dp #(
        .LINE_CELLS (LINE_CELLS),
        .VIEW_CELLS (VIEW_CELLS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_char_code        (i_char_code),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_res_stall        (i_res_stall),
        .o_res_valid        (o_res_valid),
        .o_cursor_out       (o_cursor_out),
        .o_view_top_out     (o_view_top_out),
        .o_cursor_reg_write (o_cursor_reg_write),
        .o_start_reg_write  (o_start_reg_write),
        .o_cell_write       (o_cell_write),
        .o_cell_addr        (o_cell_addr),
        .o_cell_char        (o_cell_char),
        .o_cell_attr        (o_cell_attr)
    );

endmodule

>>> rtl/tcce_ctrl.sv
// Sequencer for the text console cursor engine.
module tcce_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_char_valid,
    output logic               o_char_stall,
    input  tcce_pkg::t_dp_sts  i_sts,
    output tcce_pkg::t_dp_cmd  o_cmd
);
    import tcce_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_QMUL  = 8'b0000_1000,
        S_REM   = 8'b0001_0000,
        S_WALK  = 8'b0010_0000,
        S_UP    = 8'b0100_0000,
        S_DN    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_char_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_QMUL;
            end
            S_QMUL: begin
                o_cmd.qmul = 1'b1;
                n_state    = S_REM;
            end
            S_REM: begin
                o_cmd.rem = 1'b1;
                if (i_sts.walk) begin
                    n_state = S_WALK;
                end else if (i_sts.bs_hit) begin
                    n_state = S_UP;
                end else begin
                    n_state = S_DN;
                end
            end
            S_WALK: begin
                if (i_sts.walk_more) begin
                    o_cmd.walk = 1'b1;
                end else begin
                    n_state = S_UP;
                end
            end
            S_UP: begin
                o_cmd.up = 1'b1;
                n_state  = S_DN;
            end
            S_DN: begin
                if (i_sts.out_free) begin
                    o_cmd.dn = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_char_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_char_valid) |=> (r_state == S_MUL))
        else $error("accepted item did not start the multiply step");
    a_dn_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.dn |-> i_sts.out_free)
        else $error("result loaded while result register busy");
    a_walk_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ($past(r_state == S_REM) || $past(r_state == S_WALK)))
        else $error("space walk entered from a wrong step");
`endif

endmodule

>>> rtl/tcce_dp.sv
// Datapath: config registers, cursor/view state, space-flag memory, result register.
module tcce_dp #(
    parameter int LINE_CELLS = 80,
    parameter int VIEW_CELLS = 2000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [7:0]                          i_char_code,
    input  tcce_pkg::t_dp_cmd                   i_cmd,
    output tcce_pkg::t_dp_sts                   o_sts,
    input  logic                                i_res_stall,
    output logic                                o_res_valid,
    output logic [13:0]                         o_cursor_out,
    output logic [13:0]                         o_view_top_out,
    output logic                                o_cursor_reg_write,
    output logic                                o_start_reg_write,
    output logic                                o_cell_write,
    output logic [13:0]                         o_cell_addr,
    output logic [7:0]                          o_cell_char,
    output logic [7:0]                          o_cell_attr
);
    import tcce_pkg::*;

    // Remainder by reciprocal: q0 = off*RECIP >> RSH is the quotient or one less
    localparam int RSH   = 16;
    localparam int RECIP = (1 << RSH) / LINE_CELLS;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = CELL_AW + RW;
    localparam int QW    = PW - RSH;
    localparam int LW    = $clog2(LINE_CELLS + 1);
    localparam int MW    = QW + LW;
    localparam int SW    = CELL_AW + 2;

    localparam logic [CELL_AW-1:0] LINE_A = CELL_AW'(LINE_CELLS);
    localparam logic [SW-1:0]      LINE_S = SW'(LINE_CELLS);
    localparam logic [SW-1:0]      VIEW_S = SW'(VIEW_CELLS);

    // Config registers
    logic [CELL_AW-1:0] r_base;
    logic [14:0]        r_cells;
    logic [7:0]         r_attr;
    logic               r_active;

    // Console state
    logic [CELL_AW-1:0] r_cur;
    logic [CELL_AW-1:0] r_view;
    logic [CELL_AW-1:0] r_clr_cnt;
    logic               r_out_valid;

    // Per-item working registers
    logic [7:0]         r_ch;
    logic [CELL_AW-1:0] r_off;
    logic [PW-1:0]      r_prod;
    logic [CELL_AW-1:0] r_qline;
    logic               r_scr;
    logic               r_wr;
    logic [CELL_AW-1:0] r_wr_addr;
    logic [7:0]         r_wr_char;
    logic [7:0]         r_wr_attr;

    // Space flag per cell; only the space test ever reads a cell back
    logic               r_mem [MEM_CELLS];
    logic               r_rd_sp;

    // Result register
    logic [CELL_AW-1:0] r_o_cur;
    logic [CELL_AW-1:0] r_o_view;
    logic               r_o_cur_wr;
    logic               r_o_start_wr;
    logic               r_o_wr;
    logic [CELL_AW-1:0] r_o_addr;
    logic [7:0]         r_o_char;
    logic [7:0]         r_o_attr;

    logic [SW-1:0]      limit;
    logic [QW-1:0]      q0;
    logic [MW-1:0]      qprod;
    logic [CELL_AW-1:0] rem_raw;
    logic [CELL_AW-1:0] rem;
    logic               is_nl;
    logic               is_bs;
    logic               cur_gt_base;
    logic               nl_ok;
    logic [CELL_AW-1:0] nl_cur;
    logic               print_ok;
    logic               erase;
    logic               step;
    logic               mem_we;
    logic [CELL_AW-1:0] mem_wa;
    logic               mem_wd;
    logic [CELL_AW-1:0] mem_ra;
    logic [CELL_AW-1:0] n_cur;
    logic [CELL_AW-1:0] n_view;
    logic               up_hit;
    logic [SW-1:0]      view_end;
    logic               dn_hit;
    logic [CELL_AW-1:0] dn_view;

    // Shared decode
    always_comb begin
        limit       = SW'(r_base) + SW'(r_cells);
        q0          = r_prod[PW-1:RSH];
        qprod       = MW'(q0) * MW'(LINE_CELLS);
        rem_raw     = r_off - r_qline;
        rem         = (rem_raw >= LINE_A) ? (rem_raw - LINE_A) : rem_raw;
        is_nl       = (r_ch == CH_NEWLINE);
        is_bs       = (r_ch == CH_BACKSPACE);
        cur_gt_base = (r_cur > r_base);
        nl_ok       = (SW'(r_cur) + LINE_S) < limit;
        nl_cur      = CELL_AW'(SW'(r_base) + SW'(r_off) - SW'(rem) + LINE_S);
        print_ok    = !is_nl && !is_bs && (SW'(r_cur) < limit);
        erase       = is_bs && cur_gt_base && !((rem == '0) && r_rd_sp);
        view_end    = SW'(r_view) + VIEW_S;
        dn_hit      = (SW'(r_cur) >= view_end);
        dn_view     = (dn_hit && (view_end < limit)) ? (r_view + LINE_A) : r_view;
        up_hit      = (r_cur < r_view);
    end

    // Status to controller
    always_comb begin
        o_sts           = '0;
        o_sts.clr_done  = &r_clr_cnt;
        o_sts.walk      = is_bs && cur_gt_base && (rem == '0) && r_rd_sp;
        o_sts.bs_hit    = is_bs && cur_gt_base;
        o_sts.walk_more = cur_gt_base && r_rd_sp;
        o_sts.out_free  = !r_out_valid || !i_res_stall;
    end

    // Memory port selection
    always_comb begin
        step   = (i_cmd.rem && o_sts.walk) || (i_cmd.walk && o_sts.walk_more);
        mem_ra = step ? (r_cur - CELL_AW'(2)) : (r_cur - CELL_AW'(1));
        mem_we = i_cmd.clr || (i_cmd.rem && (print_ok || erase));
        if (i_cmd.clr) begin
            mem_wa = r_clr_cnt;
            mem_wd = 1'b0;
        end else if (erase) begin
            mem_wa = r_cur - CELL_AW'(1);
            mem_wd = 1'b1;
        end else begin
            mem_wa = r_cur;
            mem_wd = (r_ch == CH_SPACE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_sp <= r_mem[mem_ra];
    end

    // Cursor and view next values
    always_comb begin
        n_cur = r_cur;
        if (i_cmd.rem) begin
            if (is_nl) begin
                if (nl_ok) begin
                    n_cur = nl_cur;
                end
            end else if (is_bs) begin
                if (cur_gt_base) begin
                    n_cur = r_cur - CELL_AW'(1);
                end
            end else if (print_ok) begin
                n_cur = r_cur + CELL_AW'(1);
            end
        end
        if (i_cmd.walk) begin
            n_cur = r_cur - CELL_AW'(1);
        end

        n_view = r_view;
        if (i_cmd.up && up_hit && (r_view > r_base)) begin
            n_view = r_view - LINE_A;
        end
        if (i_cmd.dn) begin
            n_view = dn_view;
        end
    end

    // Control state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= RST_REGION_BASE;
            r_cells     <= RST_REGION_CELLS;
            r_attr      <= RST_TEXT_ATTR;
            r_active    <= RST_DISPLAY_ACTIVE;
            r_cur       <= RST_START_CURSOR;
            r_view      <= RST_REGION_BASE;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_REGION_BASE:    r_base   <= i_cfg_data[CELL_AW-1:0];
                    CFG_REGION_CELLS:   r_cells  <= i_cfg_data[14:0];
                    CFG_TEXT_ATTR:      r_attr   <= i_cfg_data[7:0];
                    CFG_DISPLAY_ACTIVE: r_active <= i_cfg_data[0];
                    // start cursor only matters at reset; other indexes ignored
                    default: begin
                    end
                endcase
            end
            r_cur  <= n_cur;
            r_view <= n_view;
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + CELL_AW'(1);
            end
            if (i_cmd.dn) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-item working registers and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch      <= i_char_code;
            r_off     <= (r_cur >= r_base) ? (r_cur - r_base) : '0;
            r_scr     <= 1'b0;
            r_wr      <= 1'b0;
            r_wr_addr <= '0;
            r_wr_char <= '0;
            r_wr_attr <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_off) * PW'(RECIP);
        end
        if (i_cmd.qmul) begin
            r_qline <= CELL_AW'(qprod);
        end
        if (i_cmd.rem && erase) begin
            r_wr      <= 1'b1;
            r_wr_addr <= r_cur - CELL_AW'(1);
            r_wr_char <= CH_SPACE;
            r_wr_attr <= ERASE_ATTR;
        end else if (i_cmd.rem && print_ok) begin
            r_wr      <= 1'b1;
            r_wr_addr <= r_cur;
            r_wr_char <= r_ch;
            r_wr_attr <= r_attr;
        end
        if (i_cmd.up && up_hit) begin
            r_scr <= 1'b1;
        end
        if (i_cmd.dn) begin
            r_o_cur      <= r_cur;
            r_o_view     <= dn_view;
            r_o_cur_wr   <= r_active;
            r_o_start_wr <= r_active && (r_scr || dn_hit);
            r_o_wr       <= r_wr;
            r_o_addr     <= r_wr_addr;
            r_o_char     <= r_wr_char;
            r_o_attr     <= r_wr_attr;
        end
    end

    assign o_res_valid        = r_out_valid;
    assign o_cursor_out       = r_o_cur;
    assign o_view_top_out     = r_o_view;
    assign o_cursor_reg_write = r_o_cur_wr;
    assign o_start_reg_write  = r_o_start_wr;
    assign o_cell_write       = r_o_wr;
    assign o_cell_addr        = r_o_addr;
    assign o_cell_char        = r_o_char;
    assign o_cell_attr        = r_o_attr;

`ifndef SYNTHESIS
    a_dn_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dn |=> r_out_valid)
        else $error("result not presented after load");
    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rem |-> (rem < LINE_A))
        else $error("line remainder out of range");
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_wr) |-> (r_o_addr == '0 && r_o_char == '0 && r_o_attr == '0))
        else $error("cell fields not cleared without a cell write");
`endif

endmodule

>>> dv/tb_text_console_cursor_engine_core.sv
// Self-checking testbench for the text console cursor and scroll engine.
`timescale 1ns / 100ps

module tb_text_console_cursor_engine_core;
    import tcce_pkg::*;

    localparam int unsigned LINE_CELLS    = 80;
    localparam int unsigned VIEW_CELLS    = 2000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 3_000_000;
    localparam int          PHASES        = 9;
    localparam int          PHASE_ITEMS   = 80;
    // first index past the register list; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = CFG_DISPLAY_ACTIVE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX = '1;

    // One result item as seen on the output ports
    typedef struct packed {
        logic [13:0] cursor;
        logic [13:0] view_top;
        logic        cursor_wr;
        logic        start_wr;
        logic        cell_wr;
        logic [13:0] cell_addr;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } console_res_t;

    // Directed table row: a register write or one character item
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [7:0]           code;
        bit                   known;
        console_res_t         want;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_char_valid;
    logic                  o_char_stall;
    logic [7:0]            i_char_code;
    logic                  o_res_valid;
    logic                  i_res_stall;
    logic [13:0]           o_cursor_out;
    logic [13:0]           o_view_top_out;
    logic                  o_cursor_reg_write;
    logic                  o_start_reg_write;
    logic                  o_cell_write;
    logic [13:0]           o_cell_addr;
    logic [7:0]            o_cell_char;
    logic [7:0]            o_cell_attr;

    // Console mirror: registers, cursor, view and cell memory
    int unsigned cfg_base;
    int unsigned cfg_cells;
    logic [7:0]  cfg_attr;
    logic        cfg_active;
    int unsigned mirror_cursor;
    int unsigned mirror_view;
    logic [15:0] cell_mirror [MEM_CELLS];

    console_res_t pending_res[$];
    int           fail_count;
    int           cycle_count;
    int           send_calm;

    text_console_cursor_engine_core #(
        .LINE_CELLS (LINE_CELLS),
        .VIEW_CELLS (VIEW_CELLS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_char_valid       (i_char_valid),
        .o_char_stall       (o_char_stall),
        .i_char_code        (i_char_code),
        .o_res_valid        (o_res_valid),
        .i_res_stall        (i_res_stall),
        .o_cursor_out       (o_cursor_out),
        .o_view_top_out     (o_view_top_out),
        .o_cursor_reg_write (o_cursor_reg_write),
        .o_start_reg_write  (o_start_reg_write),
        .o_cell_write       (o_cell_write),
        .o_cell_addr        (o_cell_addr),
        .o_cell_char        (o_cell_char),
        .o_cell_attr        (o_cell_attr)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("text_console_cursor_engine_core verification failed");
        $finish;
    end

    function automatic console_res_t res(input int unsigned cur, input int unsigned view,
                                         input bit crw, input bit srw, input bit cw,
                                         input int unsigned addr, input int unsigned ch,
                                         input int unsigned at);
        console_res_t r;
        r.cursor    = 14'(cur);
        r.view_top  = 14'(view);
        r.cursor_wr = crw;
        r.start_wr  = srw;
        r.cell_wr   = cw;
        r.cell_addr = 14'(addr);
        r.cell_char = 8'(ch);
        r.cell_attr = 8'(at);
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic dir_row_t char_row(input logic [7:0] code, input bit known = 1'b0,
                                          input console_res_t want = '0);
        dir_row_t row;
        row = '{default: '0};
        row.code  = code;
        row.known = known;
        row.want  = want;
        return row;
    endfunction

    // Console behavior for one character; updates the mirror state
    function automatic console_res_t console_step(input logic [7:0] code);
        int unsigned  lim;
        int unsigned  cur;
        int unsigned  off;
        int unsigned  prv;
        bit           scrolled;
        console_res_t r;
        lim      = cfg_base + cfg_cells;
        cur      = mirror_cursor;
        scrolled = 1'b0;
        r        = '0;
        if (code == CH_NEWLINE) begin
            // next line start, measured from the base; below base counts as offset zero
            if (cur + LINE_CELLS < lim) begin
                off = (cur >= cfg_base) ? cur - cfg_base : 0;
                cur = ((off / LINE_CELLS + 1) * LINE_CELLS + cfg_base) % MEM_CELLS;
            end
        end else if (code == CH_BACKSPACE) begin
            if (cur > cfg_base) begin
                prv = cur - 1;
                if ((cur - cfg_base) % LINE_CELLS == 0 && cell_mirror[prv][7:0] == CH_SPACE)
                begin
                    // walk back over the run of spaces, stop at the base
                    cur = prv;
                    while (cur > cfg_base && cell_mirror[cur - 1][7:0] == CH_SPACE)
                        cur = cur - 1;
                end else begin
                    cell_mirror[prv] = {ERASE_ATTR, CH_SPACE};
                    r.cell_wr   = 1'b1;
                    r.cell_addr = 14'(prv);
                    r.cell_char = CH_SPACE;
                    r.cell_attr = ERASE_ATTR;
                    cur = prv;
                end
                // scroll up one line; view holds at the base
                if (cur < mirror_view) begin
                    if (mirror_view > cfg_base)
                        mirror_view = (mirror_view + MEM_CELLS - LINE_CELLS) % MEM_CELLS;
                    scrolled = 1'b1;
                end
            end
        end else if (cur < lim) begin
            cell_mirror[cur % MEM_CELLS] = {cfg_attr, code};
            r.cell_wr   = 1'b1;
            r.cell_addr = 14'(cur);
            r.cell_char = code;
            r.cell_attr = cfg_attr;
            cur = (cur + 1) % MEM_CELLS;
        end
        // scroll down one line; view holds past the region end
        if (cur >= mirror_view + VIEW_CELLS) begin
            if (mirror_view + VIEW_CELLS < lim)
                mirror_view = (mirror_view + LINE_CELLS) % MEM_CELLS;
            scrolled = 1'b1;
        end
        mirror_cursor = cur;
        r.cursor    = 14'(mirror_cursor);
        r.view_top  = 14'(mirror_view);
        r.cursor_wr = cfg_active;
        r.start_wr  = scrolled & cfg_active;
        return r;
    endfunction

    // Wait before an item; now and then a run of back-to-back items
    function automatic int pick_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left = $urandom_range(8, 40);
        return $urandom_range(0, 10);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // Register write; the mirror follows at once
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_REGION_BASE:    cfg_base   = data[13:0];
            CFG_REGION_CELLS:   cfg_cells  = data;
            CFG_TEXT_ATTR:      cfg_attr   = data[7:0];
            CFG_DISPLAY_ACTIVE: cfg_active = data[0];
            default: ;  // start cursor is only loaded at reset
        endcase
        @(posedge i_clk);
    endtask

    // Present one character item and hold it until accepted
    task automatic send_char(input logic [7:0] code, input bit known = 1'b0,
                             input console_res_t want = '0);
        int           gap;
        console_res_t pred;
        gap = pick_wait(send_calm);
        if (gap > 0) begin
            i_char_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_char_valid <= 1'b1;
        i_char_code  <= code;
        do @(posedge i_clk); while (o_char_stall !== 1'b0);
        pred = console_step(code);
        pending_res.push_back(known ? want : pred);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        i_char_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register settings for one random phase
    task automatic setup_phase(input int ph);
        logic [CFG_DATA_W-1:0] base_v;
        logic [CFG_DATA_W-1:0] cells_v;
        base_v  = CFG_DATA_W'($urandom_range(0, 16383));
        cells_v = CFG_DATA_W'($urandom_range(0, 16384));
        case (ph)
            0: begin base_v = '0; cells_v = RST_REGION_CELLS; end
            1, 4: begin base_v = '0; cells_v = CFG_DATA_W'(16384); end
            3: begin
                base_v  = CFG_DATA_W'($urandom_range(16300, 16383));
                cells_v = CFG_DATA_W'(16384);
            end
            5: begin
                base_v  = CFG_DATA_W'($urandom_range(0, 200));
                cells_v = CFG_DATA_W'($urandom_range(1, 300));
            end
            6: cells_v = '0;
            7: begin
                if ($urandom_range(0, 1)) base_v = CFG_DATA_W'(16383);
                if ($urandom_range(0, 1)) cells_v = CFG_DATA_W'(16384);
            end
            8: begin base_v = '0; cells_v = RST_REGION_CELLS; end
            default: ;
        endcase
        // upper bit of the base field is junk the block must drop
        base_v[14] = 1'($urandom_range(0, 1));
        write_reg(CFG_REGION_BASE, base_v);
        write_reg(CFG_REGION_CELLS, cells_v);
        write_reg(CFG_START_CURSOR, CFG_DATA_W'($urandom_range(0, 32767)));
        if (ph == 8) begin
            write_reg(CFG_TEXT_ATTR, 15'h00FF);
            write_reg(CFG_DISPLAY_ACTIVE, 15'h0000);
        end else begin
            write_reg(CFG_TEXT_ATTR, CFG_DATA_W'($urandom_range(0, 32767)));
            write_reg(CFG_DISPLAY_ACTIVE,
                      {14'($urandom_range(0, 16383)),
                       1'(ph < 2 || $urandom_range(0, 3) != 0)});
        end
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_NO_REG, CFG_TOP_IDX)),
                      CFG_DATA_W'($urandom_range(0, 32767)));
    endtask

    // One burst of typing: text, space runs, newlines, backspace runs
    task automatic play_burst(output int sent);
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        sent = 0;
        if (kind < 30) begin
            send_char(8'($urandom_range(0, 255)));
            sent = 1;
        end else if (kind < 45) begin
            len = $urandom_range(1, 12);
            repeat (len)
                send_char(($urandom_range(0, 4) == 0) ? CH_SPACE
                                                       : 8'($urandom_range(8'h21, 8'h7E)));
            sent = len;
        end else if (kind < 57) begin
            len = $urandom_range(1, 100);
            repeat (len) send_char(CH_SPACE);
            sent = len;
        end else if (kind < 75) begin
            send_char(CH_NEWLINE);
            sent = 1;
        end else if (kind < 93) begin
            len = $urandom_range(1, 15);
            repeat (len) send_char(CH_BACKSPACE);
            sent = len;
        end else begin
            // pad with spaces up to a line start, then back over them
            if (mirror_cursor >= cfg_base)
                len = LINE_CELLS - (mirror_cursor - cfg_base) % LINE_CELLS;
            else
                len = $urandom_range(1, LINE_CELLS);
            repeat (len) send_char(CH_SPACE);
            sent = len + $urandom_range(1, 4);
            repeat (sent - len) send_char(CH_BACKSPACE);
        end
    endtask

    // Result side: random stall, then compare with the oldest expectation
    initial begin
        console_res_t w;
        int           n;
        int           calm;
        i_res_stall = 1'b0;
        calm        = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            n = pick_wait(calm);
            if (n > 0) begin
                i_res_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_res_stall <= 1'b0;
            do @(posedge i_clk); while (o_res_valid !== 1'b1);
            if (pending_res.size() == 0) begin
                report_mismatch("result with nothing expected, cursor", o_cursor_out, 0);
            end else begin
                w = pending_res.pop_front();
                if (o_cursor_out !== w.cursor)
                    report_mismatch("cursor", o_cursor_out, w.cursor);
                if (o_view_top_out !== w.view_top)
                    report_mismatch("view top", o_view_top_out, w.view_top);
                if (o_cursor_reg_write !== w.cursor_wr)
                    report_mismatch("cursor reg write", o_cursor_reg_write, w.cursor_wr);
                if (o_start_reg_write !== w.start_wr)
                    report_mismatch("start reg write", o_start_reg_write, w.start_wr);
                if (o_cell_write !== w.cell_wr)
                    report_mismatch("cell write", o_cell_write, w.cell_wr);
                if (o_cell_addr !== w.cell_addr)
                    report_mismatch("cell addr", o_cell_addr, w.cell_addr);
                if (o_cell_char !== w.cell_char)
                    report_mismatch("cell char", o_cell_char, w.cell_char);
                if (o_cell_attr !== w.cell_attr)
                    report_mismatch("cell attr", o_cell_attr, w.cell_attr);
            end
        end
    end

    // Main sequence: reset, directed table, random phases, final verdict
    initial begin
        dir_row_t rows[$];
        int       ph;
        int       sent;
        int       total;
        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_char_valid = 1'b0;
        i_char_code  = '0;
        fail_count   = 0;
        send_calm    = 0;
        cfg_base      = RST_REGION_BASE;
        cfg_cells     = RST_REGION_CELLS;
        cfg_attr      = RST_TEXT_ATTR;
        cfg_active    = RST_DISPLAY_ACTIVE;
        mirror_cursor = RST_START_CURSOR;
        mirror_view   = RST_REGION_BASE;
        foreach (cell_mirror[a]) cell_mirror[a] = '0;

        // after reset: print extremes, erase, newline, walk back over spaces
        rows.push_back(char_row(8'h41, 1, res(1, 0, 1, 0, 1, 0, 8'h41, 8'h07)));
        rows.push_back(char_row(8'hFF, 1, res(2, 0, 1, 0, 1, 1, 8'hFF, 8'h07)));
        rows.push_back(char_row(8'h00, 1, res(3, 0, 1, 0, 1, 2, 8'h00, 8'h07)));
        rows.push_back(char_row(CH_BACKSPACE));
        rows.push_back(char_row(CH_NEWLINE));
        rows.push_back(char_row(CH_BACKSPACE));
        rows.push_back(char_row(CH_BACKSPACE));
        rows.push_back(char_row(CH_NEWLINE));
        rows.push_back(char_row(CH_BACKSPACE));
        // attribute extremes, strobes off
        rows.push_back(cfg_row(CFG_TEXT_ATTR, 15'h00FF));
        rows.push_back(cfg_row(CFG_DISPLAY_ACTIVE, 15'h0000));
        rows.push_back(char_row(8'h7F, 1, res(79, 0, 0, 0, 1, 78, 8'h7F, 8'hFF)));
        rows.push_back(cfg_row(CFG_TEXT_ATTR, 15'h0000));
        rows.push_back(cfg_row(CFG_DISPLAY_ACTIVE, 15'h0001));
        rows.push_back(cfg_row(CFG_TOP_IDX, 15'h7FFF));
        rows.push_back(char_row(CH_SPACE, 1, res(80, 0, 1, 0, 1, 79, 8'h20, 8'h00)));
        // cursor below the base: backspace does nothing, newline lands on base + line
        rows.push_back(cfg_row(CFG_REGION_BASE, 15'd100));
        rows.push_back(char_row(CH_BACKSPACE, 1, res(80, 0, 1, 0, 0, 0, 0, 0)));
        rows.push_back(char_row(CH_NEWLINE));
        // empty region: nothing printed, newline blocked
        rows.push_back(cfg_row(CFG_REGION_CELLS, 15'd0));
        rows.push_back(char_row(8'h78, 1, res(180, 0, 1, 0, 0, 0, 0, 0)));
        rows.push_back(char_row(CH_NEWLINE, 1, res(180, 0, 1, 0, 0, 0, 0, 0)));
        // scroll down, then scroll down held at the region end
        rows.push_back(cfg_row(CFG_REGION_BASE, 15'd2000));
        rows.push_back(cfg_row(CFG_REGION_CELLS, 15'd16384));
        rows.push_back(char_row(CH_NEWLINE));
        rows.push_back(cfg_row(CFG_REGION_CELLS, 15'd0));
        rows.push_back(char_row(8'h79, 1, res(2080, 80, 1, 1, 0, 0, 0, 0)));
        // cursor wraps past the top of the cell memory
        rows.push_back(cfg_row(CFG_REGION_BASE, 15'd16303));
        rows.push_back(cfg_row(CFG_REGION_CELLS, 15'd16384));
        rows.push_back(cfg_row(CFG_START_CURSOR, 15'd16383));
        rows.push_back(char_row(CH_NEWLINE));
        rows.push_back(char_row(8'h7A, 1, res(0, 160, 1, 0, 1, 16383, 8'h7A, 8'h00)));
        // cursor now above the view: erase scrolls up; backspace at the base is a no-op
        rows.push_back(cfg_row(CFG_REGION_BASE, 15'd0));
        rows.push_back(char_row(8'h71));
        rows.push_back(char_row(CH_BACKSPACE));
        rows.push_back(char_row(CH_BACKSPACE, 1, res(0, 80, 1, 0, 0, 0, 0, 0)));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                drain_results();
                write_reg(rows[k].reg_idx, rows[k].reg_val);
            end else begin
                send_char(rows[k].code, rows[k].known, rows[k].want);
            end
        end

        // random phases, each under its own register settings
        for (ph = 0; ph < PHASES; ph++) begin
            drain_results();
            setup_phase(ph);
            total = 0;
            while (total < PHASE_ITEMS) begin
                play_burst(sent);
                total += sent;
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("text_console_cursor_engine_core verification clean");
        else
            $display("text_console_cursor_engine_core verification failed");
        $finish;
    end

endmodule
